// ===== sv/afd_pkg.sv =====
// Shared types and constants of the API frame deframer.
package afd_pkg;

  localparam logic [7:0] START_BYTE = 8'h7E;
  localparam logic [7:0] ESC_BYTE   = 8'h7D;
  localparam logic [7:0] ESC_XOR    = 8'h20;
  localparam logic [7:0] CSUM_BASE  = 8'hFF;

  localparam logic [1:0] STATUS_BUSY = 2'd0;
  localparam logic [1:0] STATUS_GOOD = 2'd1;
  localparam logic [1:0] STATUS_BAD  = 2'd2;

  typedef enum logic [4:0] {
    PH_HUNT   = 5'b00001,
    PH_LEN_HI = 5'b00010,
    PH_LEN_LO = 5'b00100,
    PH_DATA   = 5'b01000,
    PH_CSUM   = 5'b10000
  } phase_e;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        first_of_frame;
    logic        last_of_frame;
    logic [1:0]  frame_status;
    logic [15:0] frame_length;
  } result_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] rx_byte;
  } held_byte_t;

endpackage

// ===== sv/afd_if.sv =====
// Channel interfaces for received bytes, results and the configuration register.
interface afd_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface afd_res_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic        first_of_frame;
  logic        last_of_frame;
  logic [1:0]  frame_status;
  logic [15:0] frame_length;
  modport source (output valid, output data_byte, output first_of_frame,
                  output last_of_frame, output frame_status, output frame_length,
                  input ready);
  modport sink   (input valid, input data_byte, input first_of_frame,
                  input last_of_frame, input frame_status, input frame_length,
                  output ready);
endinterface

interface afd_cfg_if;
  logic valid;
  logic ready;
  logic escape_enable;
  modport source (output valid, output escape_enable, input ready);
  modport sink   (input valid, input escape_enable, output ready);
endinterface

// ===== sv/afd_in_stage.sv =====
// Input register that holds one received byte until the parser takes it.
module afd_in_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic [7:0]          in_byte_i,
  output logic                in_ready_o,
  input  logic                take_i,
  output afd_pkg::held_byte_t held_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  logic       accept;

  assign in_ready_o = !valid_q || take_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q <= in_byte_i;
    end
  end

  assign held_o.valid   = valid_q;
  assign held_o.rx_byte = byte_q;

endmodule

// ===== sv/afd_parser.sv =====
// Frame parser: unescaping, header and content tracking, checksum and result register.
module afd_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic                cfg_escape_enable_i,
  input  afd_pkg::held_byte_t held_i,
  output logic                take_o,
  output logic                res_valid_o,
  input  logic                res_ready_i,
  output afd_pkg::result_t    res_o
);

  afd_pkg::phase_e  phase_q, phase_d;
  logic             esc_en_q, esc_en_d;
  logic             esc_pend_q, esc_pend_d;
  logic [15:0]      len_q, len_d;
  logic [15:0]      left_q, left_d;
  logic [7:0]       sum_q, sum_d;
  logic             first_q, first_d;
  logic             res_valid_q, res_valid_d;
  afd_pkg::result_t res_q, res_d;

  logic       fire;
  logic       skip;
  logic       was_esc;
  logic [7:0] b;
  logic [7:0] expect_sum;

  assign take_o = held_i.valid && (!res_valid_q || res_ready_i);
  assign fire   = take_o;
  assign expect_sum = afd_pkg::CSUM_BASE - sum_q;

  always_comb begin
    phase_d     = phase_q;
    esc_en_d    = esc_en_q;
    esc_pend_d  = esc_pend_q;
    len_d       = len_q;
    left_d      = left_q;
    sum_d       = sum_q;
    first_d     = first_q;
    res_d       = res_q;
    res_valid_d = res_valid_q && !res_ready_i;
    skip        = 1'b0;
    was_esc     = 1'b0;
    b           = held_i.rx_byte;

    if (cfg_valid_i) begin
      esc_en_d = cfg_escape_enable_i;
    end

    if (fire) begin
      if (!esc_en_q) begin
        esc_pend_d = 1'b0;
      end else if (esc_pend_q) begin
        esc_pend_d = 1'b0;
        was_esc    = 1'b1;
        b          = held_i.rx_byte ^ afd_pkg::ESC_XOR;
      end else if (held_i.rx_byte == afd_pkg::ESC_BYTE) begin
        esc_pend_d = 1'b1;
        skip       = 1'b1;
      end

      if (!skip) begin
        unique case (phase_q)
          afd_pkg::PH_LEN_HI: begin
            len_d   = {b, 8'h00};
            phase_d = afd_pkg::PH_LEN_LO;
          end
          afd_pkg::PH_LEN_LO: begin
            len_d   = {len_q[15:8], b};
            left_d  = {len_q[15:8], b};
            phase_d = ({len_q[15:8], b} == 16'd0) ? afd_pkg::PH_CSUM : afd_pkg::PH_DATA;
          end
          afd_pkg::PH_DATA: begin
            sum_d                   = sum_q + b;
            res_d.data_byte         = b;
            res_d.first_of_frame    = first_q;
            res_d.last_of_frame     = 1'b0;
            res_d.frame_status      = afd_pkg::STATUS_BUSY;
            res_d.frame_length      = len_q;
            res_valid_d             = 1'b1;
            first_d                 = 1'b0;
            left_d                  = left_q - 16'd1;
            if (left_q == 16'd1) begin
              phase_d = afd_pkg::PH_CSUM;
            end
          end
          afd_pkg::PH_CSUM: begin
            res_d.data_byte      = b;
            res_d.first_of_frame = first_q;
            res_d.last_of_frame  = 1'b1;
            res_d.frame_status   = (b == expect_sum) ? afd_pkg::STATUS_GOOD
                                                     : afd_pkg::STATUS_BAD;
            res_d.frame_length   = len_q;
            res_valid_d          = 1'b1;
            first_d              = 1'b0;
            left_d               = 16'd0;
            phase_d              = afd_pkg::PH_HUNT;
          end
          default: begin
            phase_d = afd_pkg::PH_HUNT;
            if (!was_esc && b == afd_pkg::START_BYTE) begin
              phase_d = afd_pkg::PH_LEN_HI;
              len_d   = 16'd0;
              left_d  = 16'd0;
              sum_d   = 8'd0;
              first_d = 1'b1;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= afd_pkg::PH_HUNT;
      esc_en_q    <= 1'b1;
      esc_pend_q  <= 1'b0;
      len_q       <= 16'd0;
      left_q      <= 16'd0;
      sum_q       <= 8'd0;
      first_q     <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      esc_en_q    <= esc_en_d;
      esc_pend_q  <= esc_pend_d;
      len_q       <= len_d;
      left_q      <= left_d;
      sum_q       <= sum_d;
      first_q     <= first_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

// ===== sv/api_frame_deframer_unit.sv =====
// Top level of the API frame deframer.
// The block takes one received byte per beat and, once a downstream sink keeps up, sustains one
// beat per clock cycle on both sides. A byte passes through the input register and then the result
// register before its result beat is offered, as the parse logic works from the input register
// straight into the result register. Escape, start and length bytes give no result beat; each
// content byte gives one, and the checksum byte closes the frame with a beat marked last that
// carries the checksum status. When the result register is held by the sink, one further byte is
// taken into the input register before the receive channel stalls. The configuration register is
// written through its own channel in any cycle and should only change while no byte is in flight.
module api_frame_deframer_unit (
  input  logic clk_i,
  input  logic rst_ni,
  afd_rx_if.sink    rx_i,
  afd_cfg_if.sink   cfg_i,
  afd_res_if.source res_o
);

  afd_pkg::held_byte_t held;
  afd_pkg::result_t    res;
  logic                take;

  assign cfg_i.ready = 1'b1;

  afd_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (rx_i.valid),
    .in_byte_i  (rx_i.rx_byte),
    .in_ready_o (rx_i.ready),
    .take_i     (take),
    .held_o     (held)
  );

  afd_parser u_parser (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_valid_i         (cfg_i.valid),
    .cfg_escape_enable_i (cfg_i.escape_enable),
    .held_i              (held),
    .take_o              (take),
    .res_valid_o         (res_o.valid),
    .res_ready_i         (res_o.ready),
    .res_o               (res)
  );

  assign res_o.data_byte      = res.data_byte;
  assign res_o.first_of_frame = res.first_of_frame;
  assign res_o.last_of_frame  = res.last_of_frame;
  assign res_o.frame_status   = res.frame_status;
  assign res_o.frame_length   = res.frame_length;

endmodule

// ===== sv/afd_checker.sv =====
// Port-level assertions for the API frame deframer and their binding to the top level.
module afd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        rx_ready,
  input logic        res_valid,
  input logic        res_ready,
  input logic [7:0]  res_data_byte,
  input logic        res_first,
  input logic        res_last,
  input logic [1:0]  res_status
);

  logic expect_first_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expect_first_q <= 1'b1;
    end else if (res_valid && res_ready) begin
      expect_first_q <= res_last;
    end
  end

  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res_ready |=> res_valid && $stable(res_data_byte))
    else $error("Result beat changed while stalled.");

  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> (res_last == (res_status != afd_pkg::STATUS_BUSY)))
    else $error("Frame status does not match the last marker.");

  a_first_marker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && res_ready |-> res_first == expect_first_q)
    else $error("First marker out of step with frame boundaries.");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rx_ready |-> res_valid)
    else $error("Receive channel stalled without a pending result beat.");

endmodule

bind api_frame_deframer_unit afd_checker u_afd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .rx_ready      (rx_i.ready),
  .res_valid     (res_o.valid),
  .res_ready     (res_o.ready),
  .res_data_byte (res_o.data_byte),
  .res_first     (res_o.first_of_frame),
  .res_last      (res_o.last_of_frame),
  .res_status    (res_o.frame_status)
);

// ===== tb/afd_checker.sv =====
// Checker that predicts the result beats of the API frame deframer and compares them.
module afd_tb_checker (
  input  logic clk_i,
  input  logic rst_ni,
  afd_rx_if    rx_mon,
  afd_cfg_if   cfg_mon,
  afd_res_if   res_mon,
  output int   mismatches_o,
  output int   outstanding_o,
  output logic hunting_o
);

  logic             esc_en_q   = 1'b1;
  afd_pkg::phase_e  phase_q    = afd_pkg::PH_HUNT;
  logic             esc_wait_q = 1'b0;
  logic [15:0]      len_q      = '0;
  logic [15:0]      left_q     = '0;
  logic [7:0]       sum_q      = '0;
  logic             first_q    = 1'b0;
  int               errors     = 0;
  afd_pkg::result_t results_due[$];

  function automatic bit deframe_byte(input logic [7:0] raw, output afd_pkg::result_t res);
    logic [7:0] b;
    logic       escaped;
    logic [7:0] want_sum;
    res     = '0;
    escaped = 1'b0;
    if (!esc_en_q) begin
      esc_wait_q = 1'b0;
      b          = raw;
    end else if (esc_wait_q) begin
      esc_wait_q = 1'b0;
      escaped    = 1'b1;
      b          = raw ^ afd_pkg::ESC_XOR;
    end else if (raw == afd_pkg::ESC_BYTE) begin
      esc_wait_q = 1'b1;
      return 1'b0;
    end else begin
      b = raw;
    end
    case (phase_q)
      afd_pkg::PH_LEN_HI: begin
        len_q   = {b, 8'h00};
        phase_q = afd_pkg::PH_LEN_LO;
        return 1'b0;
      end
      afd_pkg::PH_LEN_LO: begin
        len_q[7:0] = b;
        left_q     = len_q;
        phase_q    = (len_q == 16'd0) ? afd_pkg::PH_CSUM : afd_pkg::PH_DATA;
        return 1'b0;
      end
      afd_pkg::PH_DATA: begin
        sum_q   = sum_q + b;
        res     = '{data_byte: b, first_of_frame: first_q, last_of_frame: 1'b0,
                    frame_status: afd_pkg::STATUS_BUSY, frame_length: len_q};
        first_q = 1'b0;
        left_q  = left_q - 16'd1;
        if (left_q == 16'd0) phase_q = afd_pkg::PH_CSUM;
        return 1'b1;
      end
      afd_pkg::PH_CSUM: begin
        want_sum = afd_pkg::CSUM_BASE - sum_q;
        res      = '{data_byte: b, first_of_frame: first_q, last_of_frame: 1'b1,
                     frame_status: (b == want_sum) ? afd_pkg::STATUS_GOOD
                                                   : afd_pkg::STATUS_BAD,
                     frame_length: len_q};
        first_q  = 1'b0;
        phase_q  = afd_pkg::PH_HUNT;
        left_q   = '0;
        return 1'b1;
      end
      default: begin
        phase_q = afd_pkg::PH_HUNT;
        if (!escaped && b == afd_pkg::START_BYTE) begin
          phase_q = afd_pkg::PH_LEN_HI;
          len_q   = '0;
          left_q  = '0;
          sum_q   = '0;
          first_q = 1'b1;
        end
        return 1'b0;
      end
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    afd_pkg::result_t want;
    afd_pkg::result_t got;
    if (!rst_ni) begin
      esc_en_q   = 1'b1;
      phase_q    = afd_pkg::PH_HUNT;
      esc_wait_q = 1'b0;
      len_q      = '0;
      left_q     = '0;
      sum_q      = '0;
      first_q    = 1'b0;
      results_due.delete();
      outstanding_o <= 0;
      hunting_o     <= 1'b1;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) esc_en_q = cfg_mon.escape_enable;
      if (rx_mon.valid && rx_mon.ready) begin
        if (deframe_byte(rx_mon.rx_byte, want)) results_due.push_back(want);
      end
      if (res_mon.valid && res_mon.ready) begin
        got = '{res_mon.data_byte, res_mon.first_of_frame, res_mon.last_of_frame,
                res_mon.frame_status, res_mon.frame_length};
        if (results_due.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected result beat: byte %h first %b last %b status %0d length %h",
                     got.data_byte, got.first_of_frame, got.last_of_frame,
                     got.frame_status, got.frame_length);
        end else begin
          want = results_due.pop_front();
          if (got.data_byte !== want.data_byte || got.first_of_frame !== want.first_of_frame ||
              got.last_of_frame !== want.last_of_frame ||
              got.frame_status !== want.frame_status ||
              got.frame_length !== want.frame_length) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: expected byte %h first %b last %b status %0d length %h, %s",
                       want.data_byte, want.first_of_frame, want.last_of_frame,
                       want.frame_status, want.frame_length,
                       $sformatf("got byte %h first %b last %b status %0d length %h",
                                 got.data_byte, got.first_of_frame, got.last_of_frame,
                                 got.frame_status, got.frame_length));
          end
        end
      end
      outstanding_o <= results_due.size();
      hunting_o     <= (phase_q == afd_pkg::PH_HUNT);
    end
    mismatches_o <= errors;
  end

endmodule

// ===== tb/api_frame_deframer_unit_test.sv =====
// Testbench top of the API frame deframer: clock, reset, stimulus, idling and the verdict.
module api_frame_deframer_unit_test;

  localparam int LONG_HOLD       = 300;
  localparam int DRAIN_CYCLES    = 6;
  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int ITEMS_PER_PHASE = 270;

  logic       clk_i  = 1'b0;
  logic       rst_ni = 1'b0;
  int         rx_idle_pct   = 0;
  int         res_stall_pct = 0;
  int         hold_reqs     = 0;
  int         cycle_count   = 0;
  int         mismatches;
  int         outstanding;
  logic       hunting;
  logic       esc_on = 1'b1;
  logic [7:0] line_q[$];

  afd_rx_if  rx_ch ();
  afd_cfg_if cfg_ch ();
  afd_res_if res_ch ();

  api_frame_deframer_unit i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_ch),
    .cfg_i  (cfg_ch),
    .res_o  (res_ch)
  );

  afd_tb_checker i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .rx_mon        (rx_ch),
    .cfg_mon       (cfg_ch),
    .res_mon       (res_ch),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding),
    .hunting_o     (hunting)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // The receiver stalls at random; a new hold request keeps ready low for a long stretch.
  initial begin : result_sink
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_seen != hold_reqs) begin
        hold_seen = hold_reqs;
        hold_left = LONG_HOLD;
        res_ch.ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= ($urandom_range(0, 99) >= res_stall_pct);
      end
    end
  end

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 10))
      0: return afd_pkg::START_BYTE;
      1: return afd_pkg::ESC_BYTE;
      2: return afd_pkg::START_BYTE ^ afd_pkg::ESC_XOR;
      3: return 8'h00;
      4: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic void put_coded(input logic [7:0] b, input int esc_pct);
    if (esc_on && (b == afd_pkg::ESC_BYTE || $urandom_range(0, 99) < esc_pct)) begin
      line_q.push_back(afd_pkg::ESC_BYTE);
      line_q.push_back(b ^ afd_pkg::ESC_XOR);
    end else begin
      line_q.push_back(b);
    end
  endfunction

  function automatic void build_frame(input logic [15:0] len, input bit bad_sum,
                                      input int esc_pct);
    logic [7:0] sum;
    logic [7:0] b;
    logic [7:0] csum;
    sum = 8'h00;
    line_q.push_back(afd_pkg::START_BYTE);
    put_coded(len[15:8], esc_pct);
    put_coded(len[7:0], esc_pct);
    for (int i = 0; i < int'(len); i++) begin
      b   = pick_byte();
      sum = sum + b;
      put_coded(b, esc_pct);
    end
    csum = afd_pkg::CSUM_BASE - sum;
    if (bad_sum) csum = csum ^ 8'($urandom_range(1, 255));
    put_coded(csum, esc_pct);
  endfunction

  // Noise never starts a frame and never leaves an escape open.
  function automatic void build_noise(input int count);
    logic [7:0] b;
    repeat (count) begin
      do b = pick_byte(); while (b == afd_pkg::START_BYTE);
      line_q.push_back(b);
      if (esc_on && b == afd_pkg::ESC_BYTE) line_q.push_back(pick_byte());
    end
  endfunction

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < rx_idle_pct) begin
      rx_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= b;
    @(posedge clk_i);
    while (!rx_ch.ready) @(posedge clk_i);
  endtask

  task automatic send_line();
    foreach (line_q[i]) send_byte(line_q[i]);
    line_q.delete();
  endtask

  // Pads a cut-off frame with zero bytes until the checker model of the deframer hunts again.
  task automatic close_frame();
    rx_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (!hunting) begin
      send_byte(8'h00);
      rx_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic drain_results();
    rx_ch.valid <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_escape(input logic en);
    cfg_ch.valid         <= 1'b1;
    cfg_ch.escape_enable <= en;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    cfg_ch.valid <= 1'b0;
    esc_on = en;
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct, input int n_items);
    int          sent;
    int          kind;
    logic [15:0] len;
    rx_idle_pct   = idle_pct;
    res_stall_pct = stall_pct;
    sent          = 0;
    while (sent < n_items) begin
      kind = $urandom_range(0, 99);
      len  = ($urandom_range(0, 24) == 0) ? 16'($urandom_range(11, 600))
                                          : 16'($urandom_range(0, 10));
      if (kind < 75) begin
        build_frame(len, $urandom_range(0, 9) == 0, $urandom_range(0, 30));
        sent += line_q.size();
        send_line();
      end else if (kind < 88) begin
        build_frame(len, 1'b0, $urandom_range(0, 30));
        repeat ($urandom_range(1, line_q.size() - 1)) void'(line_q.pop_back());
        sent += line_q.size();
        send_line();
        close_frame();
      end else begin
        build_noise($urandom_range(1, 6));
        sent += line_q.size();
        send_line();
      end
    end
    drain_results();
  endtask

  initial begin
    rx_ch.valid          <= 1'b0;
    rx_ch.rx_byte        <= 8'h00;
    cfg_ch.valid         <= 1'b0;
    cfg_ch.escape_enable <= 1'b1;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    line_q = '{8'h00, 8'hFF, afd_pkg::ESC_BYTE, afd_pkg::START_BYTE ^ afd_pkg::ESC_XOR,
               8'h00, 8'h00, afd_pkg::CSUM_BASE,
               afd_pkg::START_BYTE, 8'h00, 8'h00, afd_pkg::CSUM_BASE,
               afd_pkg::START_BYTE, 8'h00, 8'h02, afd_pkg::START_BYTE, afd_pkg::ESC_BYTE,
               afd_pkg::ESC_BYTE ^ afd_pkg::ESC_XOR,
               afd_pkg::CSUM_BASE - afd_pkg::START_BYTE - afd_pkg::ESC_BYTE,
               afd_pkg::START_BYTE, 8'h00, 8'h00, 8'h00};
    send_line();
    drain_results();

    hold_reqs++;
    repeat (4) build_frame(16'd8, 1'b0, 20);
    send_line();
    drain_results();

    write_escape(1'b1);
    run_phase(0, 0, ITEMS_PER_PHASE);

    line_q = '{afd_pkg::START_BYTE, 8'h00, 8'h01, afd_pkg::ESC_BYTE};
    send_line();
    drain_results();
    write_escape(1'b0);
    line_q = '{afd_pkg::ESC_BYTE, afd_pkg::CSUM_BASE - afd_pkg::ESC_BYTE};
    send_line();
    run_phase(45, 0, ITEMS_PER_PHASE);

    line_q = '{afd_pkg::START_BYTE, 8'h00, 8'h01};
    send_line();
    drain_results();
    write_escape(1'b1);
    line_q = '{afd_pkg::ESC_BYTE, afd_pkg::START_BYTE ^ afd_pkg::ESC_XOR,
               afd_pkg::CSUM_BASE - afd_pkg::START_BYTE};
    send_line();
    run_phase(0, 45, ITEMS_PER_PHASE);

    write_escape(1'b0);
    run_phase(14, 14, ITEMS_PER_PHASE);

    write_escape(1'b1);
    rx_idle_pct   = 0;
    res_stall_pct = 0;
    build_frame(16'h0110, 1'b0, 2);
    send_line();
    drain_results();

    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
